/* rtl/rotr_pkg.sv */
// shared constants and types for the segment align point rotator
package rotr_pkg;

    localparam int COORD_BITS_DEF     = 16;
    localparam int COEF_FRAC_BITS_DEF = 16;

    // configuration register map
    localparam int NUM_REGS   = 8;
    localparam int REG_IDX_W  = 3;
    localparam int APB_DATA_W = 32;
    localparam int PADDR_W    = 5;

    localparam int REG_A_SX = 0;
    localparam int REG_A_SY = 1;
    localparam int REG_A_EX = 2;
    localparam int REG_A_EY = 3;
    localparam int REG_B_SX = 4;
    localparam int REG_B_SY = 5;
    localparam int REG_B_EX = 6;
    localparam int REG_B_EY = 7;

    // queue sizes and back end stage count
    localparam int Q_DEPTH     = 2;
    localparam int OUT_DEPTH   = 4;
    localparam int BACK_STAGES = 3;

    typedef struct packed {
        logic ready;
        logic degen;
    } t_coef_status;

endpackage

/* rtl/rotr_fifo.sv */
// small register-based first-in first-out queue
module rotr_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic                       i_pop,
    input  logic [WIDTH-1:0]           i_data,
    output logic [WIDTH-1:0]           o_data,
    output logic                       o_empty,
    output logic                       o_full,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH+1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr;
    logic [AW-1:0]    r_rd;
    logic [CW-1:0]    r_cnt;
    logic             w_do_push;
    logic             w_do_pop;

    assign o_empty   = (r_cnt == '0);
    assign o_full    = (r_cnt == CW'(DEPTH));
    assign o_count   = r_cnt;
    assign o_data    = r_mem[r_rd];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_do_push) begin
                r_wr <= (r_wr == AW'(DEPTH-1)) ? '0 : r_wr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH-1)) ? '0 : r_rd + 1'b1;
            end
            if (w_do_push && !w_do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_do_pop && !w_do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

/* rtl/rotr_coef.sv */
// coefficient sequencer: midpoints, integer magnitude by square root, fraction division
module rotr_coef #(
    parameter int COORD_BITS     = rotr_pkg::COORD_BITS_DEF,
    parameter int COEF_FRAC_BITS = rotr_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic signed [COORD_BITS-1:0]   i_cfg [rotr_pkg::NUM_REGS],
    output logic signed [COEF_FRAC_BITS+1:0] o_cos,
    output logic signed [COEF_FRAC_BITS+1:0] o_sin,
    output logic signed [COORD_BITS-1:0]   o_mid_a_x,
    output logic signed [COORD_BITS-1:0]   o_mid_a_y,
    output logic signed [COORD_BITS-1:0]   o_mid_b_x,
    output logic signed [COORD_BITS-1:0]   o_mid_b_y,
    output rotr_pkg::t_coef_status         o_status
);
    import rotr_pkg::*;

    localparam int CB   = COORD_BITS;
    localparam int F    = COEF_FRAC_BITS;
    localparam int TW   = CB + 1;
    localparam int PW2  = 2 * TW;
    localparam int MW   = 2 * TW + 1;
    localparam int PW   = 2 * MW;
    localparam int RMW  = MW + 3;
    localparam int CW   = F + 2;
    localparam int CNTW = $clog2(MW + F + 2);

    typedef enum logic [3:0] {
        S_IDLE, S_DIFF, S_PROD, S_SUM, S_ABS, S_MUL, S_SQRT, S_DIVI, S_DIV, S_FIN
    } t_state;

    t_state                r_state;
    logic [CNTW-1:0]       r_cnt;
    logic signed [TW-1:0]  r_r1x, r_r1y, r_r2x, r_r2y;
    logic signed [PW2-1:0] r_sq1x, r_sq1y, r_sq2x, r_sq2y;
    logic signed [PW2-1:0] r_pd1, r_pd2, r_pc1, r_pc2;
    logic [MW-1:0]         r_m1, r_m2;
    logic signed [MW-1:0]  r_dot, r_crs;
    logic [MW-1:0]         r_adot, r_acrs;
    logic [PW-1:0]         r_prod, r_mcand;
    logic [MW-1:0]         r_mplier;
    logic [RMW-1:0]        r_rem;
    logic [MW-1:0]         r_root;
    logic [MW:0]           r_rc, r_rs;
    logic [F:0]            r_qc, r_qs;
    logic                  r_degen;

    logic [RMW-1:0] w_rem_sh;
    logic [RMW-1:0] w_trial;
    logic [MW:0]    w_den;
    logic [MW:0]    w_rc2, w_rs2;

    function automatic logic signed [CB-1:0] half_trunc(input logic signed [TW-1:0] s);
        logic signed [TW-1:0] t;
        t = s + TW'(s[TW-1] & s[0]);
        return t[TW-1:1];
    endfunction

    assign w_rem_sh = {r_rem[RMW-3:0], r_prod[PW-1:PW-2]};
    assign w_trial  = RMW'({r_root, 2'b01});
    assign w_den    = {1'b0, r_root};
    assign w_rc2    = {r_rc[MW-1:0], 1'b0};
    assign w_rs2    = {r_rs[MW-1:0], 1'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            o_status <= '0;
            r_cnt    <= '0;
        end else if (i_start) begin
            r_state        <= S_DIFF;
            o_status.ready <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                end
                S_DIFF: begin
                    r_r1x <= TW'(i_cfg[REG_A_EX]) - TW'(i_cfg[REG_A_SX]);
                    r_r1y <= TW'(i_cfg[REG_A_EY]) - TW'(i_cfg[REG_A_SY]);
                    r_r2x <= TW'(i_cfg[REG_B_SX]) - TW'(i_cfg[REG_B_EX]);
                    r_r2y <= TW'(i_cfg[REG_B_SY]) - TW'(i_cfg[REG_B_EY]);
                    o_mid_a_x <= half_trunc(TW'(i_cfg[REG_A_SX]) + TW'(i_cfg[REG_A_EX]));
                    o_mid_a_y <= half_trunc(TW'(i_cfg[REG_A_SY]) + TW'(i_cfg[REG_A_EY]));
                    o_mid_b_x <= half_trunc(TW'(i_cfg[REG_B_SX]) + TW'(i_cfg[REG_B_EX]));
                    o_mid_b_y <= half_trunc(TW'(i_cfg[REG_B_SY]) + TW'(i_cfg[REG_B_EY]));
                    r_state <= S_PROD;
                end
                S_PROD: begin
                    r_sq1x  <= r_r1x * r_r1x;
                    r_sq1y  <= r_r1y * r_r1y;
                    r_sq2x  <= r_r2x * r_r2x;
                    r_sq2y  <= r_r2y * r_r2y;
                    r_pd1   <= r_r1x * r_r2x;
                    r_pd2   <= r_r1y * r_r2y;
                    r_pc1   <= r_r1x * r_r2y;
                    r_pc2   <= r_r1y * r_r2x;
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_m1    <= MW'($unsigned(r_sq1x)) + MW'($unsigned(r_sq1y));
                    r_m2    <= MW'($unsigned(r_sq2x)) + MW'($unsigned(r_sq2y));
                    r_dot   <= MW'(r_pd1) + MW'(r_pd2);
                    r_crs   <= MW'(r_pc1) - MW'(r_pc2);
                    r_state <= S_ABS;
                end
                S_ABS: begin
                    r_degen  <= (r_m1 == '0) || (r_m2 == '0);
                    r_adot   <= r_dot[MW-1] ? MW'(-r_dot) : MW'(r_dot);
                    r_acrs   <= r_crs[MW-1] ? MW'(-r_crs) : MW'(r_crs);
                    r_mcand  <= PW'(r_m1);
                    r_mplier <= r_m2;
                    r_prod   <= '0;
                    r_cnt    <= '0;
                    r_state  <= ((r_m1 == '0) || (r_m2 == '0)) ? S_FIN : S_MUL;
                end
                S_MUL: begin
                    // shift-add product of the two squared lengths
                    if (r_mplier[0]) begin
                        r_prod <= r_prod + r_mcand;
                    end
                    r_mcand  <= r_mcand << 1;
                    r_mplier <= r_mplier >> 1;
                    if (r_cnt == CNTW'(MW-1)) begin
                        r_cnt   <= '0;
                        r_rem   <= '0;
                        r_root  <= '0;
                        r_state <= S_SQRT;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_SQRT: begin
                    // one root bit per cycle
                    r_prod <= r_prod << 2;
                    if (w_rem_sh >= w_trial) begin
                        r_rem  <= w_rem_sh - w_trial;
                        r_root <= {r_root[MW-2:0], 1'b1};
                    end else begin
                        r_rem  <= w_rem_sh;
                        r_root <= {r_root[MW-2:0], 1'b0};
                    end
                    if (r_cnt == CNTW'(MW-1)) begin
                        r_cnt   <= '0;
                        r_state <= S_DIVI;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_DIVI: begin
                    if ({1'b0, r_adot} >= w_den) begin
                        r_qc <= (F+1)'(1);
                        r_rc <= {1'b0, r_adot} - w_den;
                    end else begin
                        r_qc <= '0;
                        r_rc <= {1'b0, r_adot};
                    end
                    if ({1'b0, r_acrs} >= w_den) begin
                        r_qs <= (F+1)'(1);
                        r_rs <= {1'b0, r_acrs} - w_den;
                    end else begin
                        r_qs <= '0;
                        r_rs <= {1'b0, r_acrs};
                    end
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    // restoring division, cos and sin side by side
                    if (w_rc2 >= w_den) begin
                        r_rc <= w_rc2 - w_den;
                        r_qc <= {r_qc[F-1:0], 1'b1};
                    end else begin
                        r_rc <= w_rc2;
                        r_qc <= {r_qc[F-1:0], 1'b0};
                    end
                    if (w_rs2 >= w_den) begin
                        r_rs <= w_rs2 - w_den;
                        r_qs <= {r_qs[F-1:0], 1'b1};
                    end else begin
                        r_rs <= w_rs2;
                        r_qs <= {r_qs[F-1:0], 1'b0};
                    end
                    if (r_cnt == CNTW'(F-1)) begin
                        r_cnt   <= '0;
                        r_state <= S_FIN;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_FIN: begin
                    if (r_degen) begin
                        o_cos <= '0;
                        o_sin <= '0;
                    end else begin
                        o_cos <= r_dot[MW-1] ? -CW'(r_qc) : CW'(r_qc);
                        o_sin <= (!r_crs[MW-1] && (r_crs != '0)) ? -CW'(r_qs) : CW'(r_qs);
                    end
                    o_status.degen <= r_degen;
                    o_status.ready <= 1'b1;
                    r_state        <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

/* rtl/rotr_front.sv */
// front end: accepts points, centers them on the source midpoint, queues them
module rotr_front #(
    parameter int COORD_BITS = rotr_pkg::COORD_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic signed [COORD_BITS-1:0] i_point_x,
    input  logic signed [COORD_BITS-1:0] i_point_y,
    input  logic                        i_last_in,
    input  logic signed [COORD_BITS-1:0] i_mid_b_x,
    input  logic signed [COORD_BITS-1:0] i_mid_b_y,
    input  logic                        i_ready,
    input  logic                        i_q_pop,
    output logic                        o_q_valid,
    output logic signed [COORD_BITS:0]  o_tx,
    output logic signed [COORD_BITS:0]  o_ty,
    output logic                        o_last
);
    import rotr_pkg::*;

    localparam int TW = COORD_BITS + 1;
    localparam int QW = 2 * TW + 1;

    logic signed [TW-1:0]         w_tx, w_ty;
    logic [QW-1:0]                w_q_in, w_q_out;
    logic                         w_q_empty, w_q_full;
    logic [$clog2(Q_DEPTH+1)-1:0] w_q_cnt;

    assign w_tx   = TW'(i_point_x) - TW'(i_mid_b_x);
    assign w_ty   = TW'(i_point_y) - TW'(i_mid_b_y);
    assign w_q_in = {w_tx, w_ty, i_last_in};
    assign full   = !i_ready || w_q_full;

    rotr_fifo #(
        .WIDTH (QW),
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push && !full),
        .i_pop   (i_q_pop),
        .i_data  (w_q_in),
        .o_data  (w_q_out),
        .o_empty (w_q_empty),
        .o_full  (w_q_full),
        .o_count (w_q_cnt)
    );

    assign o_q_valid = !w_q_empty && (w_q_cnt != '0);
    assign o_tx      = w_q_out[QW-1:TW+1];
    assign o_ty      = w_q_out[TW:1];
    assign o_last    = w_q_out[0];

endmodule

/* rtl/rotr_back.sv */
// back end: rotation pipeline, truncation, offset, clamp and result queue
module rotr_back #(
    parameter int COORD_BITS     = rotr_pkg::COORD_BITS_DEF,
    parameter int COEF_FRAC_BITS = rotr_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_q_valid,
    output logic                             o_q_pop,
    input  logic signed [COORD_BITS:0]       i_tx,
    input  logic signed [COORD_BITS:0]       i_ty,
    input  logic                             i_last,
    input  logic signed [COEF_FRAC_BITS+1:0] i_cos,
    input  logic signed [COEF_FRAC_BITS+1:0] i_sin,
    input  logic signed [COORD_BITS-1:0]     i_mid_a_x,
    input  logic signed [COORD_BITS-1:0]     i_mid_a_y,
    input  rotr_pkg::t_coef_status           i_status,
    output logic                             empty,
    input  logic                             pop,
    output logic signed [COORD_BITS-1:0]     o_out_x,
    output logic signed [COORD_BITS-1:0]     o_out_y,
    output logic                             o_last_out,
    output logic                             o_degenerate,
    output logic                             o_saturated
);
    import rotr_pkg::*;

    localparam int CB  = COORD_BITS;
    localparam int F   = COEF_FRAC_BITS;
    localparam int TW  = CB + 1;
    localparam int CW  = F + 2;
    localparam int PRW = TW + CW;
    localparam int SW  = PRW + 1;
    localparam int HW  = SW - F;
    localparam int EW  = HW + 1;
    localparam int RW  = 2 * CB + 3;
    localparam int OCW = $clog2(OUT_DEPTH + 1);
    localparam int SUMW = $clog2(OUT_DEPTH + BACK_STAGES + 1);

    localparam logic signed [EW-1:0] MAXV = {{(EW-CB+1){1'b0}}, {(CB-1){1'b1}}};
    localparam logic signed [EW-1:0] MINV = {{(EW-CB+1){1'b1}}, {(CB-1){1'b0}}};

    logic                  r_v1, r_v2, r_v3;
    logic                  r_l1, r_l2, r_l3;
    logic signed [PRW-1:0] r_xc, r_ys, r_xs, r_yc;
    logic signed [SW-1:0]  r_sx, r_sy;
    logic signed [HW-1:0]  r_hx, r_hy;

    logic signed [SW-1:0]  w_bx, w_by;
    logic signed [EW-1:0]  w_ex, w_ey;
    logic signed [CB-1:0]  w_cx, w_cy;
    logic                  w_sat;
    logic [RW-1:0]         w_res, w_head;
    logic                  w_full;
    logic [OCW-1:0]        w_cnt;
    logic [SUMW-1:0]       w_busy;

    // hold back a request unless the result queue has room for everything in flight,
    // counting a result that leaves this cycle
    assign w_busy  = SUMW'(w_cnt) + SUMW'(r_v1) + SUMW'(r_v2) + SUMW'(r_v3);
    assign o_q_pop = i_q_valid && (w_busy < SUMW'(OUT_DEPTH) + SUMW'(pop && !empty));

    // truncation toward zero: bias negatives before the arithmetic shift
    assign w_bx = r_sx + {{(SW-F){1'b0}}, {F{r_sx[SW-1]}}};
    assign w_by = r_sy + {{(SW-F){1'b0}}, {F{r_sy[SW-1]}}};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= o_q_pop;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_xc <= i_tx * i_cos;
        r_ys <= i_ty * i_sin;
        r_xs <= i_tx * i_sin;
        r_yc <= i_ty * i_cos;
        r_l1 <= i_last;
        r_sx <= SW'(r_xc) - SW'(r_ys);
        r_sy <= SW'(r_xs) + SW'(r_yc);
        r_l2 <= r_l1;
        r_hx <= w_bx[SW-1:F];
        r_hy <= w_by[SW-1:F];
        r_l3 <= r_l2;
    end

    always_comb begin
        w_ex  = EW'(r_hx) + EW'(i_mid_a_x);
        w_ey  = EW'(r_hy) + EW'(i_mid_a_y);
        w_sat = 1'b0;
        if (w_ex > MAXV) begin
            w_cx  = MAXV[CB-1:0];
            w_sat = 1'b1;
        end else if (w_ex < MINV) begin
            w_cx  = MINV[CB-1:0];
            w_sat = 1'b1;
        end else begin
            w_cx = w_ex[CB-1:0];
        end
        if (w_ey > MAXV) begin
            w_cy  = MAXV[CB-1:0];
            w_sat = 1'b1;
        end else if (w_ey < MINV) begin
            w_cy  = MINV[CB-1:0];
            w_sat = 1'b1;
        end else begin
            w_cy = w_ey[CB-1:0];
        end
        if (i_status.degen) begin
            w_res = {{(2*CB){1'b0}}, r_l3, 1'b1, 1'b0};
        end else begin
            w_res = {w_cx, w_cy, r_l3, 1'b0, w_sat};
        end
    end

    rotr_fifo #(
        .WIDTH (RW),
        .DEPTH (OUT_DEPTH)
    ) u_results (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_v3),
        .i_pop   (pop),
        .i_data  (w_res),
        .o_data  (w_head),
        .o_empty (empty),
        .o_full  (w_full),
        .o_count (w_cnt)
    );

    assign o_out_x      = w_head[RW-1:CB+3];
    assign o_out_y      = w_head[CB+2:3];
    assign o_last_out   = w_head[2];
    assign o_degenerate = w_head[1];
    assign o_saturated  = w_head[0];

endmodule

/* rtl/segment_align_point_rotator.sv */
// top level: configuration registers, coefficient unit, front and back ends
//
// Maps a stream of points rigidly from the frame of segment B onto the frame of
// segment A. After reset and after every register write, a coefficient sequencer
// derives cos, sin and both midpoints from the eight endpoint registers by way of a
// bit-serial product and a one-bit-per-cycle square root, and full stays high
// until it is done. After that a point is taken every cycle while the queues have
// room: the front end centers it on B's midpoint and queues it, the back end
// rotates, truncates, offsets and clamps it in three register stages and then
// writes it to the result queue. Zero-length segments give zero points with
// degenerate set.
module segment_align_point_rotator #(
    parameter int COORD_BITS     = rotr_pkg::COORD_BITS_DEF,
    parameter int COEF_FRAC_BITS = rotr_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // point requests
    input  logic                                push,
    output logic                                full,
    input  logic signed [COORD_BITS-1:0]        i_point_x,
    input  logic signed [COORD_BITS-1:0]        i_point_y,
    input  logic                                i_last_in,
    // results
    output logic                                empty,
    input  logic                                pop,
    output logic signed [COORD_BITS-1:0]        o_out_x,
    output logic signed [COORD_BITS-1:0]        o_out_y,
    output logic                                o_last_out,
    output logic                                o_degenerate,
    output logic                                o_saturated,
    // register port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rotr_pkg::PADDR_W-1:0]        paddr,
    input  logic [rotr_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [rotr_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import rotr_pkg::*;

    localparam int CB = COORD_BITS;
    localparam int F  = COEF_FRAC_BITS;

    logic signed [CB-1:0] r_cfg [NUM_REGS];
    logic                 r_kick;          // restart coefficient sequencer
    logic                 w_wr;
    logic [REG_IDX_W-1:0] w_idx;

    logic signed [F+1:0]  w_cos, w_sin;
    logic signed [CB-1:0] w_mid_a_x, w_mid_a_y, w_mid_b_x, w_mid_b_y;
    t_coef_status         w_status;
    t_coef_status         w_back_status;
    logic                 w_ready;

    logic                 w_q_valid, w_q_pop, w_q_last;
    logic signed [CB:0]   w_tx, w_ty;

    // register access: word addresses, no wait states
    assign pready = 1'b1;
    assign w_idx  = paddr[REG_IDX_W+1:2];
    assign w_wr   = psel && penable && pwrite && pready;
    assign prdata = APB_DATA_W'($unsigned(r_cfg[w_idx]));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kick <= 1'b1;
        end else begin
            r_kick <= w_wr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                r_cfg[i] <= '0;
            end
        end else if (w_wr) begin
            r_cfg[w_idx] <= pwdata[CB-1:0];
        end
    end

    // a write drops readiness at once, the sequencer restarts the cycle after
    assign w_ready = w_status.ready && !r_kick;

    rotr_coef #(
        .COORD_BITS     (CB),
        .COEF_FRAC_BITS (F)
    ) u_coef (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_kick),
        .i_cfg     (r_cfg),
        .o_cos     (w_cos),
        .o_sin     (w_sin),
        .o_mid_a_x (w_mid_a_x),
        .o_mid_a_y (w_mid_a_y),
        .o_mid_b_x (w_mid_b_x),
        .o_mid_b_y (w_mid_b_y),
        .o_status  (w_status)
    );

    rotr_front #(
        .COORD_BITS (CB)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .push      (push),
        .full      (full),
        .i_point_x (i_point_x),
        .i_point_y (i_point_y),
        .i_last_in (i_last_in),
        .i_mid_b_x (w_mid_b_x),
        .i_mid_b_y (w_mid_b_y),
        .i_ready   (w_ready),
        .i_q_pop   (w_q_pop),
        .o_q_valid (w_q_valid),
        .o_tx      (w_tx),
        .o_ty      (w_ty),
        .o_last    (w_q_last)
    );

    assign w_back_status = '{ready: w_ready, degen: w_status.degen};

    rotr_back #(
        .COORD_BITS     (CB),
        .COEF_FRAC_BITS (F)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (w_q_valid && w_back_status.ready),
        .o_q_pop      (w_q_pop),
        .i_tx         (w_tx),
        .i_ty         (w_ty),
        .i_last       (w_q_last),
        .i_cos        (w_cos),
        .i_sin        (w_sin),
        .i_mid_a_x    (w_mid_a_x),
        .i_mid_a_y    (w_mid_a_y),
        .i_status     (w_back_status),
        .empty        (empty),
        .pop          (pop),
        .o_out_x      (o_out_x),
        .o_out_y      (o_out_y),
        .o_last_out   (o_last_out),
        .o_degenerate (o_degenerate),
        .o_saturated  (o_saturated)
    );

endmodule

/* rtl/rotr_checker.sv */
// port-level checks for the segment align point rotator, bound to the top level
module rotr_checker #(
    parameter int COORD_BITS = rotr_pkg::COORD_BITS_DEF
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         psel,
    input logic                         penable,
    input logic                         pwrite,
    input logic                         full,
    input logic                         empty,
    input logic                         pop,
    input logic signed [COORD_BITS-1:0] o_out_x,
    input logic signed [COORD_BITS-1:0] o_out_y,
    input logic                         o_degenerate,
    input logic                         o_saturated
);
    localparam logic signed [COORD_BITS-1:0] MAXV = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [COORD_BITS-1:0] MINV = {1'b1, {(COORD_BITS-1){1'b0}}};

    // a register write blocks new requests while coefficients are rebuilt
    a_write_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable && pwrite) |=> full)
        else $error("request accepted right after a register write");

    // degenerate results are zero points and never clamped
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_degenerate) |-> (o_out_x == '0 && o_out_y == '0 && !o_saturated))
        else $error("degenerate result is not a zero point");

    // a clamped result sits on the edge of the coordinate range
    a_sat_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_saturated) |->
        (o_out_x == MAXV || o_out_x == MINV || o_out_y == MAXV || o_out_y == MINV))
        else $error("saturated result not at range limit");

    // an untaken result stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_out_x) && $stable(o_out_y)))
        else $error("waiting result changed");

endmodule

bind segment_align_point_rotator rotr_checker #(.COORD_BITS(COORD_BITS)) u_rotr_checker (.*);

/* verif/segment_align_point_rotator_tb.sv */
// testbench for the segment align point rotator: scoreboard, stimulus and checks
module segment_align_point_rotator_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import rotr_pkg::*;

    localparam int CB = COORD_BITS_DEF;
    localparam int FB = COEF_FRAC_BITS_DEF;
    localparam longint CYCLE_LIMIT = 3000000;

    typedef struct {
        logic signed [CB-1:0] px;
        logic signed [CB-1:0] py;
        logic                 last;
        logic signed [CB-1:0] ox;
        logic signed [CB-1:0] oy;
        logic                 degen;
        logic                 sat;
    } t_point_req;

    // rotation predictor with its own copy of registers and coefficients
    class rotation_scoreboard;
        logic signed [CB-1:0] seg_reg[NUM_REGS];
        longint cos_c, sin_c, mid_ax, mid_ay, mid_bx, mid_by;
        bit coef_valid, degen_flag;
        t_point_req pending_points[$];
        int errors, checked, degen_seen, sat_seen;

        function void clear_state();
            foreach (seg_reg[i]) seg_reg[i] = '0;
            cos_c = 0; sin_c = 0;
            mid_ax = 0; mid_ay = 0; mid_bx = 0; mid_by = 0;
            coef_valid = 0; degen_flag = 0;
        endfunction

        function void write_reg(int idx, logic [31:0] val);
            if (idx < NUM_REGS) begin
                seg_reg[idx] = val[CB-1:0];
                coef_valid = 0;
            end
        endfunction

        static function longint halve(longint s);
            return (s < 0) ? -((-s) / 2) : s / 2;
        endfunction

        static function longint drop_frac(longint v);
            return (v < 0) ? -((-v) >>> FB) : (v >>> FB);
        endfunction

        // floor(sqrt(p)) on an exact 128 bit product
        static function longint root_of(logic [127:0] p);
            logic [63:0] r;
            logic [63:0] c;
            r = '0;
            for (int b = 63; b >= 0; b--) begin
                c = r | (64'd1 << b);
                if (128'(c) * 128'(c) <= p) r = c;
            end
            return longint'(r);
        endfunction

        function void derive_coefs();
            longint r1x, r1y, r2x, r2y, m1, m2, dp, cp, mag, c, s;
            r1x = longint'(seg_reg[REG_A_EX]) - longint'(seg_reg[REG_A_SX]);
            r1y = longint'(seg_reg[REG_A_EY]) - longint'(seg_reg[REG_A_SY]);
            r2x = longint'(seg_reg[REG_B_SX]) - longint'(seg_reg[REG_B_EX]);
            r2y = longint'(seg_reg[REG_B_SY]) - longint'(seg_reg[REG_B_EY]);
            m1 = r1x * r1x + r1y * r1y;
            m2 = r2x * r2x + r2y * r2y;
            mid_ax = halve(longint'(seg_reg[REG_A_SX]) + longint'(seg_reg[REG_A_EX]));
            mid_ay = halve(longint'(seg_reg[REG_A_SY]) + longint'(seg_reg[REG_A_EY]));
            mid_bx = halve(longint'(seg_reg[REG_B_SX]) + longint'(seg_reg[REG_B_EX]));
            mid_by = halve(longint'(seg_reg[REG_B_SY]) + longint'(seg_reg[REG_B_EY]));
            cos_c = 0; sin_c = 0;
            degen_flag = (m1 == 0 || m2 == 0);
            if (!degen_flag) begin
                dp = r1x * r2x + r1y * r2y;
                cp = r1x * r2y - r1y * r2x;
                mag = root_of(128'(m1) * 128'(m2));
                if (mag != 0) begin
                    // |dot|,|cross| <= mag, so the shifted value fits in 64 bits
                    c = ((dp < 0 ? -dp : dp) << FB) / mag;
                    s = ((cp < 0 ? -cp : cp) << FB) / mag;
                    cos_c = dp < 0 ? -c : c;
                    sin_c = cp > 0 ? -s : s;
                end
            end
            coef_valid = 1;
        endfunction

        function logic signed [CB-1:0] clamp(longint v, inout logic sat);
            longint hi, lo;
            hi = (longint'(1) << (CB - 1)) - 1;
            lo = -hi - 1;
            if (v > hi) begin v = hi; sat = 1; end
            if (v < lo) begin v = lo; sat = 1; end
            return v[CB-1:0];
        endfunction

        function void note_point(logic signed [CB-1:0] px, logic signed [CB-1:0] py,
                                 logic last);
            t_point_req e;
            longint tx, ty;
            if (!coef_valid) derive_coefs();
            e.px = px; e.py = py; e.last = last; e.sat = 0;
            e.degen = degen_flag;
            if (degen_flag) begin
                e.ox = '0; e.oy = '0;
            end else begin
                tx = longint'(px) - mid_bx;
                ty = longint'(py) - mid_by;
                e.ox = clamp(drop_frac(tx * cos_c - ty * sin_c) + mid_ax, e.sat);
                e.oy = clamp(drop_frac(tx * sin_c + ty * cos_c) + mid_ay, e.sat);
            end
            pending_points.insert(pending_points.size(), e);
        endfunction

        function void check_result(logic signed [CB-1:0] ox, logic signed [CB-1:0] oy,
                                   logic last, logic degen, logic sat);
            t_point_req e;
            if (pending_points.size() == 0) begin
                $display("%0t: unexpected result x=%0d y=%0d", $time, ox, oy);
                errors++;
                return;
            end
            e = pending_points.pop_front();
            checked++;
            if (degen) degen_seen++;
            if (sat) sat_seen++;
            if (ox !== e.ox || oy !== e.oy || last !== e.last || degen !== e.degen
                    || sat !== e.sat) begin
                $display("%0t: point (%0d,%0d) expected x=%0d y=%0d last=%b degen=%b sat=%b",
                         $time, e.px, e.py, e.ox, e.oy, e.last, e.degen, e.sat);
                $display("%0t:   actual x=%0d y=%0d last=%b degen=%b sat=%b",
                         $time, ox, oy, last, degen, sat);
                errors++;
            end
        endfunction
    endclass

    logic i_clk, i_rst_n;
    logic push, full, empty, pop;
    logic signed [CB-1:0] i_point_x, i_point_y, o_out_x, o_out_y;
    logic i_last_in, o_last_out, o_degenerate, o_saturated;
    logic psel, penable, pwrite, pready;
    logic [PADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata, prdata;

    segment_align_point_rotator u_top (
        .i_clk, .i_rst_n,
        .push, .full, .i_point_x, .i_point_y, .i_last_in,
        .empty, .pop, .o_out_x, .o_out_y, .o_last_out, .o_degenerate, .o_saturated,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    rotation_scoreboard sb = new();

    // idle percentages for sender and receiver, changed per phase
    int send_idle_pct, recv_idle_pct;
    bit hold_off;
    longint cycle_count;
    int points_sent;

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    // run guard
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("timeout after %0d cycles, %0d results still due",
                         cycle_count, sb.pending_points.size());
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // receiver: pop decided at the falling edge, result taken at the rising edge
    initial begin
        pop = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && pop && !empty)
                sb.check_result(o_out_x, o_out_y, o_last_out, o_degenerate, o_saturated);
            @(negedge i_clk);
            pop <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // register write: setup then access cycle; the caller closes the transfer
    task automatic write_seg_reg(int idx, logic signed [CB-1:0] val);
        psel <= 1; penable <= 0; pwrite <= 1;
        paddr <= PADDR_W'(idx * 4);
        pwdata <= 32'(val);
        @(negedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        if (pready) sb.write_reg(idx, 32'(val));
        @(negedge i_clk);
    endtask

    // all eight registers back to back, only while the block is idle
    task automatic load_segments(logic signed [CB-1:0] v[NUM_REGS]);
        for (int i = 0; i < NUM_REGS; i++) write_seg_reg(i, v[i]);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    // offer one point until it is taken; called at a falling edge, push left high
    task automatic send_point(logic signed [CB-1:0] px, logic signed [CB-1:0] py,
                              logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 0;
            @(negedge i_clk);
        end
        push <= 1; i_point_x <= px; i_point_y <= py; i_last_in <= last;
        forever begin
            @(posedge i_clk);
            if (!full) break;
        end
        sb.note_point(px, py, last);
        points_sent++;
        @(negedge i_clk);
    endtask

    // stop offering, wait for every expected result, then let the pipeline settle
    task automatic drain();
        push <= 0;
        while (sb.pending_points.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    function automatic logic signed [CB-1:0] rand_coord();
        case ($urandom_range(7))
            0: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
            1, 2: return CB'($signed($urandom_range(400)) - 200);
            default: return CB'($urandom);
        endcase
    endfunction

    // random list of points, mostly well formed, in runs of one to twelve with a last marker closing each complete run
    task automatic random_points(int n);
        int run;
        run = 0;
        for (int i = 0; i < n; i++) begin
            if (run == 0) run = $urandom_range(12, 1);
            run--;
            send_point(rand_coord(), rand_coord(), run == 0);
        end
    endtask

    logic signed [CB-1:0] segs[NUM_REGS];

    initial begin
        i_rst_n = 0; push = 0; i_point_x = '0; i_point_y = '0; i_last_in = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        hold_off = 0; send_idle_pct = 0; recv_idle_pct = 0; points_sent = 0;
        sb.clear_state();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // reset values: both segments have zero length
        send_point(16'sh7fff, 16'sh8000, 0);
        send_point(16'sh0000, 16'sh0001, 1);
        drain();

        // axis-aligned segments, a quarter turn
        segs = '{0, 0, 100, 0, 0, 0, 0, 100};
        load_segments(segs);
        send_point(0, 0, 0);
        send_point(16'sh7fff, 16'sh7fff, 0);
        send_point(16'sh8000, 16'sh8000, 0);
        send_point(16'sh7fff, 16'sh8000, 0);
        send_point(16'sh8000, 16'sh7fff, 0);
        send_point(-1, 1, 1);
        drain();

        // extreme endpoints, odd sums for the midpoint truncation
        segs = '{16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff,
                 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff};
        load_segments(segs);
        send_point(16'sh7fff, 0, 0);
        send_point(16'sh8000, 16'sh8000, 0);
        send_point(-3, 5, 1);
        drain();

        // segment A of zero length only
        segs = '{5, -7, 5, -7, 1, 2, 30, 40};
        load_segments(segs);
        send_point(123, -456, 1);
        drain();

        // segments pointing in opposite directions, whose difference vectors are identical
        segs = '{-9, 3, 11, 3, 20, -1, 0, -1};
        load_segments(segs);
        send_point(16'sh7fff, 16'sh7fff, 0);
        send_point(16'sh8000, 1, 1);
        drain();

        // random phases, each with a fresh segment pair
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
                1: begin send_idle_pct = 86; recv_idle_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_idle_pct = 86; end
                default: begin send_idle_pct = 11; recv_idle_pct = 11; end
            endcase
            foreach (segs[i]) segs[i] = rand_coord();
            if (ph == 7) segs[REG_B_EX] = segs[REG_B_SX];
            if (ph == 7) segs[REG_B_EY] = segs[REG_B_SY];
            load_segments(segs);
            if (ph == 0) begin
                // long receiver hold-off so the block fills and stalls its input
                hold_off = 1;
                fork
                    begin
                        repeat (300) @(posedge i_clk);
                        hold_off = 0;
                    end
                    random_points(40);
                join
            end
            random_points(160);
            drain();
        end
        send_idle_pct = 0; recv_idle_pct = 0;
        drain();

        $display("covered %0d points, %0d checked, %0d degenerate, %0d saturated",
                 points_sent, sb.checked, sb.degen_seen, sb.sat_seen);
        if (sb.errors == 0 && sb.pending_points.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

/* segment_align_point_rotator.f */
rtl/rotr_pkg.sv
rtl/rotr_fifo.sv
rtl/rotr_coef.sv
rtl/rotr_front.sv
rtl/rotr_back.sv
rtl/segment_align_point_rotator.sv
rtl/rotr_checker.sv
verif/segment_align_point_rotator_tb.sv
